// ===== src/dhr_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dhr_pkg: shared definitions for the decimating history recorder
// Field widths of the request and response words, operation codes and the
// default sizes of the history store.
// ============================================================================
package dhr_pkg;

    // Default store geometry.
    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int SAMPLE_BITS_DEF   = 16;

    // Field widths of the channel words.
    localparam int OPERATION_W  = 1;
    localparam int SAMPLE_W     = 16;
    localparam int READ_INDEX_W = 10;
    localparam int READ_DATA_W  = 16;
    localparam int COUNT_W      = 11;
    localparam int INTERVAL_W   = 32;

    // The interval stops doubling here.
    localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 32'h8000_0000;

    // Operation codes.
    localparam logic [OPERATION_W-1:0] OP_RECORD = 1'b0;
    localparam logic [OPERATION_W-1:0] OP_READ   = 1'b1;

endpackage

// ===== src/dhr_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dhr_in_if / dhr_out_if: valid-ready channels of the history recorder
// The request channel carries operations and samples, the response channel
// carries one result word per request.
// ============================================================================
interface dhr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [dhr_pkg::OPERATION_W-1:0]      operation;
    logic [dhr_pkg::SAMPLE_W-1:0]         sample;
    logic                                 sample_unknown;
    logic [dhr_pkg::READ_INDEX_W-1:0]     read_index;

    modport source (
        output valid, operation, sample, sample_unknown, read_index,
        input  ready
    );
    modport sink (
        input  valid, operation, sample, sample_unknown, read_index,
        output ready
    );
endinterface

interface dhr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [dhr_pkg::READ_DATA_W-1:0]      read_data;
    logic [dhr_pkg::COUNT_W-1:0]          entry_count;
    logic [dhr_pkg::INTERVAL_W-1:0]       sample_interval;
    logic                                 recorded;
    logic                                 compacted;

    modport source (
        output valid, read_data, entry_count, sample_interval, recorded, compacted,
        input  ready
    );
    modport sink (
        input  valid, read_data, entry_count, sample_interval, recorded, compacted,
        output ready
    );
endinterface

// ===== src/dhr_mem.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dhr_mem: history store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module dhr_mem #(
    parameter int DEPTH = dhr_pkg::HISTORY_DEPTH_DEF,
    parameter int WIDTH = dhr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/decimating_history_recorder_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// decimating_history_recorder_unit: trace buffer with adaptive decimation
// Records one sample out of every interval samples and halves the store
// in place when it fills, doubling the interval.
// ============================================================================
// Timing: a record word that does not fill the store is answered in the cycle
// after it is accepted; a read word passes the registered read port of the
// history RAM and the S_READ state before its response is registered. A
// record word that fills the store starts a compaction pass that moves one
// entry per cycle through the RAM's single write port; its response is
// registered at the end of that pass. At most one word is in flight, and a new
// request is taken once the response register is empty or being drained. The
// store is not cleared after reset; only written entries are ever read back.

module decimating_history_recorder_unit #(
    parameter int HISTORY_DEPTH = dhr_pkg::HISTORY_DEPTH_DEF,
    parameter int SAMPLE_BITS   = dhr_pkg::SAMPLE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dhr_in_if.sink    request,
    dhr_out_if.source response
);

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int VC_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int HALF   = HISTORY_DEPTH / 2;
    localparam int K_W    = $clog2(HALF + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_COMPACT
    } state_t;

    state_t                           state_reg, state_next;
    logic [VC_W-1:0]                  vc_reg, vc_next;
    logic [dhr_pkg::INTERVAL_W-1:0]   skip_reg, skip_next;
    logic [dhr_pkg::INTERVAL_W-1:0]   interval_reg, interval_next;
    logic [K_W-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic                             hit_reg, hit_next;

    logic                             out_valid_reg, out_valid_next;
    logic [dhr_pkg::READ_DATA_W-1:0]  read_data_reg, read_data_next;
    logic [dhr_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [dhr_pkg::INTERVAL_W-1:0]   out_interval_reg, out_interval_next;
    logic                             recorded_reg, recorded_next;
    logic                             compacted_reg, compacted_next;

    logic                             mem_we;
    logic [ADDR_W-1:0]                mem_waddr;
    logic [SAMPLE_BITS-1:0]           mem_wdata;
    logic                             mem_re;
    logic [ADDR_W-1:0]                mem_raddr;
    logic [SAMPLE_BITS-1:0]           mem_rdata;

    logic                             in_ready;
    logic                             accept;
    logic                             produce;
    logic                             hit;
    logic [dhr_pkg::INTERVAL_W-1:0]   skip_inc;
    logic [dhr_pkg::INTERVAL_W-1:0]   interval_dbl;
    logic [SAMPLE_BITS-1:0]           rec_value;

    dhr_mem #(
        .DEPTH (HISTORY_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || response.ready);
    assign accept   = request.valid && in_ready;

    assign hit = (32'(request.read_index) < 32'(vc_reg))
              && (32'(request.read_index) < 32'(HISTORY_DEPTH));
    assign skip_inc     = skip_reg + 32'd1;
    assign interval_dbl = (interval_reg >= dhr_pkg::INTERVAL_MAX)
                        ? dhr_pkg::INTERVAL_MAX : (interval_reg << 1);
    assign rec_value    = request.sample_unknown ? '0 : SAMPLE_BITS'(request.sample);

    always_comb
    begin
        state_next        = state_reg;
        vc_next           = vc_reg;
        skip_next         = skip_reg;
        interval_next     = interval_reg;
        cmp_idx_next      = cmp_idx_reg;
        hit_next          = hit_reg;
        read_data_next    = read_data_reg;
        count_next        = count_reg;
        out_interval_next = out_interval_reg;
        recorded_next     = recorded_reg;
        compacted_next    = compacted_reg;
        produce           = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = vc_reg[ADDR_W-1:0];
        mem_wdata         = rec_value;
        mem_re            = 1'b0;
        mem_raddr         = ADDR_W'(request.read_index);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (request.operation == dhr_pkg::OP_READ)
                    begin
                        mem_re     = hit;
                        hit_next   = hit;
                        state_next = S_READ;
                    end
                    else if (skip_inc >= interval_reg)
                    begin
                        mem_we    = 1'b1;
                        skip_next = '0;
                        vc_next   = vc_reg + VC_W'(1);
                        if (vc_reg == VC_W'(HISTORY_DEPTH - 1))
                        begin
                            cmp_idx_next = '0;
                            state_next   = S_COMPACT;
                        end
                        else
                        begin
                            produce           = 1'b1;
                            read_data_next    = '0;
                            count_next        = dhr_pkg::COUNT_W'(vc_reg + VC_W'(1));
                            out_interval_next = interval_reg;
                            recorded_next     = 1'b1;
                            compacted_next    = 1'b0;
                        end
                    end
                    else
                    begin
                        skip_next         = skip_inc;
                        produce           = 1'b1;
                        read_data_next    = '0;
                        count_next        = dhr_pkg::COUNT_W'(vc_reg);
                        out_interval_next = interval_reg;
                        recorded_next     = 1'b0;
                        compacted_next    = 1'b0;
                    end
                end
            end
            S_READ:
            begin
                produce           = 1'b1;
                read_data_next    = hit_reg ? dhr_pkg::READ_DATA_W'(mem_rdata) : '0;
                count_next        = dhr_pkg::COUNT_W'(vc_reg);
                out_interval_next = interval_reg;
                recorded_next     = 1'b0;
                compacted_next    = 1'b0;
                state_next        = S_IDLE;
            end
            S_COMPACT:
            begin
                // Read slot 2k+1 while slot k-1 takes the word read last cycle.
                mem_re       = (cmp_idx_reg != K_W'(HALF));
                mem_raddr    = ADDR_W'({cmp_idx_reg, 1'b1});
                mem_we       = (cmp_idx_reg != '0);
                mem_waddr    = ADDR_W'(cmp_idx_reg - K_W'(1));
                mem_wdata    = mem_rdata;
                cmp_idx_next = cmp_idx_reg + K_W'(1);
                if (cmp_idx_reg == K_W'(HALF))
                begin
                    vc_next           = VC_W'(HALF);
                    interval_next     = interval_dbl;
                    produce           = 1'b1;
                    read_data_next    = '0;
                    count_next        = dhr_pkg::COUNT_W'(HALF);
                    out_interval_next = interval_dbl;
                    recorded_next     = 1'b1;
                    compacted_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = produce || (out_valid_reg && !response.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            vc_reg           <= '0;
            skip_reg         <= '0;
            interval_reg     <= 32'd1;
            cmp_idx_reg      <= '0;
            hit_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
            read_data_reg    <= '0;
            count_reg        <= '0;
            out_interval_reg <= 32'd1;
            recorded_reg     <= 1'b0;
            compacted_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vc_reg           <= vc_next;
            skip_reg         <= skip_next;
            interval_reg     <= interval_next;
            cmp_idx_reg      <= cmp_idx_next;
            hit_reg          <= hit_next;
            out_valid_reg    <= out_valid_next;
            read_data_reg    <= read_data_next;
            count_reg        <= count_next;
            out_interval_reg <= out_interval_next;
            recorded_reg     <= recorded_next;
            compacted_reg    <= compacted_next;
        end
    end

    assign request.ready            = in_ready;
    assign response.valid           = out_valid_reg;
    assign response.read_data       = read_data_reg;
    assign response.entry_count     = count_reg;
    assign response.sample_interval = out_interval_reg;
    assign response.recorded        = recorded_reg;
    assign response.compacted       = compacted_reg;

    // A new result never overwrites a word that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        produce |-> !(out_valid_reg && !response.ready))
        else $error("result produced while response word still pending");

    // During compaction a write never lands on a slot that is yet to be read.
    a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMPACT && mem_we && mem_re) |-> (mem_waddr < mem_raddr))
        else $error("compaction write overtakes its read");

    // Between words the store is never full.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (32'(vc_reg) < 32'(HISTORY_DEPTH)))
        else $error("entry count reached store depth while idle");

    // The interval is always a power of two.
    a_interval_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(interval_reg))
        else $error("interval is not a power of two");

    // The skip counter is cleared whenever it reaches the interval.
    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg < interval_reg)
        else $error("skip counter reached the interval");

endmodule
